>>> rtl/wgmt_pkg.sv
// wgmt_pkg: shared constants for the window gap max tracker.
// Used by wgmt_hist_mem and window_gap_max_tracker; no dependencies.
package wgmt_pkg;

  localparam int ScoreW    = 16;
  localparam int IndexW    = 12;
  localparam int WindowW   = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 5;

  localparam int MaxWindowDef = 16;
  localparam int MaxItemsDef  = 4096;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW_DISTANCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALVE_GAP       = 2'd1;

  localparam logic [WindowW-1:0] WINDOW_RESET = 5'd1;

endpackage

>>> rtl/window_gap_max_tracker.sv
// window_gap_max_tracker: largest gap between scores k places apart.
// Throughput: one item per cycle while no result waits on out_ready; the history
// memory is read for every item and written for the first MAX_ITEMS of a list.
// Reset: clears control, counters, max state and config; the history memory is not
// cleared, as entries are used only after being written in the current list.
module window_gap_max_tracker
  import wgmt_pkg::*;
#(
  parameter int MAX_WINDOW = MaxWindowDef,
  parameter int MAX_ITEMS  = MaxItemsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ScoreW-1:0]   in_score,
  input  logic                in_last_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ScoreW-1:0]   out_best_gap,
  output logic [IndexW-1:0]   out_best_index,
  output logic                out_found,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int KW  = $clog2(MAX_WINDOW + 1);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int EW  = (CW > KW) ? CW : KW;
  localparam int WDW = (KW > WindowW) ? KW : WindowW;
  localparam int SW  = KW + 1;

  logic [WindowW-1:0] window_distance_r;
  logic               halve_gap_r;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;

  logic               s1_valid_r;
  logic [ScoreW-1:0]  s1_score_r;
  logic               s1_last_r;
  logic               s1_check_r;
  logic [CW-1:0]      s1_lead_pos_r;

  logic [ScoreW-1:0]  max_gap_r;
  logic [CW-1:0]      max_index_r;
  logic               gap_seen_r;

  logic               out_valid_r;
  logic [ScoreW-1:0]  out_gap_r;
  logic [IndexW-1:0]  out_index_r;
  logic               out_found_r;

  logic               advance, in_fire;
  logic               cnt_active;
  logic [WDW-1:0]     wd_ext;
  logic [KW-1:0]      k_eff;
  logic               check;
  logic [EW-1:0]      lead_pos;
  logic [SW-1:0]      rsum, rwrap;
  logic [AW-1:0]      raddr;
  logic [ScoreW-1:0]  lead;

  logic               lead_gt;
  logic [ScoreW-1:0]  diff, gap;
  logic               upd;
  logic [ScoreW-1:0]  cur_gap;
  logic [CW-1:0]      cur_idx;
  logic               cur_seen;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_distance_r <= WINDOW_RESET;
      halve_gap_r       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_DISTANCE: window_distance_r <= cfg_wdata[WindowW-1:0];
        CFG_HALVE_GAP:       halve_gap_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage 0: address the lead score and write this one
  assign advance  = !(s1_valid_r && s1_last_r && out_valid_r && !out_ready);
  assign in_ready = advance;
  assign in_fire  = in_valid && advance;

  assign cnt_active = cnt_r < CW'(MAX_ITEMS);

  always_comb begin
    wd_ext = WDW'(window_distance_r);
    if (wd_ext == '0) begin
      k_eff = KW'(1);
    end else if (wd_ext > WDW'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(wd_ext);
    end
  end

  assign check    = cnt_active && (EW'(cnt_r) >= EW'(k_eff));
  assign lead_pos = EW'(cnt_r) - EW'(k_eff);

  assign rsum  = SW'(wr_ptr_r) + SW'(MAX_WINDOW) - SW'(k_eff);
  assign rwrap = (rsum >= SW'(MAX_WINDOW)) ? rsum - SW'(MAX_WINDOW) : rsum;
  assign raddr = AW'(rwrap);

  always_comb begin
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    if (in_fire) begin
      if (in_last_item) begin
        cnt_nxt    = '0;
        wr_ptr_nxt = '0;
      end else if (cnt_active) begin
        cnt_nxt    = cnt_r + CW'(1);
        wr_ptr_nxt = (wr_ptr_r == AW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  wgmt_hist_mem #(
    .Depth (MAX_WINDOW),
    .AddrW (AW)
  ) u_hist (
    .clk   (clk),
    .we    (in_fire && cnt_active),
    .waddr (wr_ptr_r),
    .wdata (in_score),
    .re    (in_fire),
    .raddr (raddr),
    .rdata (lead)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_score_r    <= in_score;
      s1_last_r     <= in_last_item;
      s1_check_r    <= check;
      s1_lead_pos_r <= CW'(lead_pos);
    end
  end

  // stage 1: gap and running max
  assign lead_gt  = s1_check_r && (lead > s1_score_r);
  assign diff     = lead - s1_score_r;
  assign gap      = halve_gap_r ? (diff >> 1) : diff;
  assign upd      = lead_gt && (gap > max_gap_r);
  assign cur_gap  = upd ? gap : max_gap_r;
  assign cur_idx  = upd ? s1_lead_pos_r : max_index_r;
  assign cur_seen = gap_seen_r || upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r   <= '0;
      max_index_r <= '0;
      gap_seen_r  <= 1'b0;
    end else if (s1_valid_r && advance) begin
      if (s1_last_r) begin
        max_gap_r   <= '0;
        max_index_r <= '0;
        gap_seen_r  <= 1'b0;
      end else begin
        max_gap_r   <= cur_gap;
        max_index_r <= cur_idx;
        gap_seen_r  <= cur_seen;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_last_r && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_last_r && advance) begin
      out_gap_r   <= cur_seen ? cur_gap : '0;
      out_index_r <= cur_seen ? IndexW'(cur_idx) : '0;
      out_found_r <= cur_seen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_gap   = out_gap_r;
  assign out_best_index = out_index_r;
  assign out_found      = out_found_r;

  // checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_item |=> cnt_r == '0 && wr_ptr_r == '0)
    else $error("count not cleared after last item");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_gap_r != '0)
    else $error("found result with zero gap");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_gap_r == '0 && out_index_r == '0)
    else $error("empty result carries data");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_last_r && out_valid_r)
    else $error("stall without a pending result");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cnt_active |=> wr_ptr_r < AW'(MAX_WINDOW - 1) || wr_ptr_r == AW'(MAX_WINDOW - 1))
    else $error("history pointer out of range");

endmodule

>>> rtl/wgmt_hist_mem.sv
// wgmt_hist_mem: score history ring, one write and one registered read port.
// Depends on wgmt_pkg for the score width and the default depth.
module wgmt_hist_mem
  import wgmt_pkg::*;
#(
  parameter int Depth = MaxWindowDef,
  parameter int AddrW = $clog2(MaxWindowDef)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  logic [ScoreW-1:0] wdata,
  input  logic              re,
  input  logic [AddrW-1:0]  raddr,
  output logic [ScoreW-1:0] rdata
);

  logic [ScoreW-1:0] mem [Depth];
  logic [ScoreW-1:0] rdata_r;

  // read-first: a read and write to the same entry return the old score
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

>>> tb/window_gap_max_tracker_tb.sv
// window_gap_max_tracker_tb: self-checking testbench for the window gap max tracker.
// Predicts each list result in place and checks it; sender bursts, receiver stalls.
// Depends on wgmt_pkg and window_gap_max_tracker.
module window_gap_max_tracker_tb;
  import wgmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int RandomItems = 1950;

  // index with no register behind it; a write there is ignored
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

  typedef struct packed {
    logic [ScoreW-1:0] gap;
    logic [IndexW-1:0] index;
    logic              found;
  } gap_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ScoreW-1:0]   in_score = '0;
  logic                in_last_item = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ScoreW-1:0]   out_best_gap;
  logic [IndexW-1:0]   out_best_index;
  logic                out_found;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  window_gap_max_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_score(in_score), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_best_gap(out_best_gap), .out_best_index(out_best_index), .out_found(out_found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [ScoreW-1:0]  score_ring [MaxWindowDef];
  int                 list_pos;
  logic [ScoreW-1:0]  top_gap;
  logic [IndexW-1:0]  top_index;
  bit                 top_seen;
  logic [WindowW-1:0] window_reg;
  bit                 halve_reg;

  gap_result_t pending_results[$];
  gap_result_t got_result;
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int random_sent = 0;

  task automatic clear_list();
    list_pos = 0;
    top_gap = '0;
    top_index = '0;
    top_seen = 1'b0;
    for (int i = 0; i < MaxWindowDef; i++) score_ring[i] = '0;
  endtask

  task automatic track_score(input logic [ScoreW-1:0] s, input bit last);
    int k;
    logic [ScoreW-1:0] lead;
    logic [ScoreW-1:0] gap;
    gap_result_t r;
    if (list_pos < MaxItemsDef) begin
      k = (window_reg == 0) ? 1 : ((window_reg > MaxWindowDef) ? MaxWindowDef : window_reg);
      if (list_pos >= k) begin
        lead = score_ring[(list_pos - k) % MaxWindowDef];
        if (lead > s) begin
          gap = lead - s;
          if (halve_reg) gap = gap >> 1;
          if (gap > top_gap) begin
            top_gap = gap;
            top_index = IndexW'(list_pos - k);
            top_seen = 1'b1;
          end
        end
      end
      score_ring[list_pos % MaxWindowDef] = s;
      list_pos++;
    end
    if (last) begin
      r.gap = top_seen ? top_gap : '0;
      r.index = top_seen ? top_index : '0;
      r.found = top_seen;
      pending_results = {pending_results, r};
      clear_list();
    end
  endtask

  task automatic send_item(input logic [ScoreW-1:0] s, input bit last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_score <= s;
    in_last_item <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_score(s, last);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WINDOW_DISTANCE) window_reg = data;
    else if (idx == CFG_HALVE_GAP) halve_reg = data[0];
    @(posedge clk);
  endtask

  task automatic send_descending(input int len, input int max_step, input bit fixed_step);
    int cur;
    int step;
    cur = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
    step = $urandom_range(0, max_step);
    for (int i = 0; i < len; i++) begin
      send_item(ScoreW'(cur), i == len - 1);
      if (!fixed_step)
        step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, max_step);
      cur = (cur - step < 0) ? 0 : cur - step;
    end
  endtask

  task automatic test_basic_lists();
    send_item(16'd7, 1'b1);
    send_item(16'hFFFF, 1'b0); send_item(16'h0000, 1'b1);
    send_item(16'd100, 1'b0); send_item(16'd50, 1'b0);
    send_item(16'd100, 1'b0); send_item(16'd50, 1'b1);
    send_item(16'd5, 1'b0); send_item(16'd5, 1'b1);
    wait_idle();
  endtask

  task automatic test_halving();
    write_reg(CfgUnusedIdx, 5'd31);
    write_reg(CFG_HALVE_GAP, 5'b00001);
    send_item(16'hFFFF, 1'b0); send_item(16'h0000, 1'b1);
    send_item(16'd10, 1'b0); send_item(16'd9, 1'b1);
    send_item(16'd11, 1'b0); send_item(16'd8, 1'b1);
    wait_idle();
    write_reg(CFG_WINDOW_DISTANCE, 5'd0);
    write_reg(CFG_HALVE_GAP, 5'b11110);
    send_item(16'd20, 1'b0); send_item(16'd10, 1'b1);
    wait_idle();
  endtask

  task automatic test_window_limits();
    write_reg(CFG_WINDOW_DISTANCE, 5'd4);
    send_item(16'd50, 1'b0); send_item(16'd40, 1'b0); send_item(16'd30, 1'b1);
    wait_idle();
    write_reg(CFG_WINDOW_DISTANCE, 5'd31);
    send_item(16'd1000, 1'b0);
    for (int i = 0; i < 15; i++) send_item(16'd900, 1'b0);
    send_item(16'd0, 1'b1);
    wait_idle();
    write_reg(CFG_WINDOW_DISTANCE, 5'd16);
    send_descending(20, 300, 1'b0);
    wait_idle();
  endtask

  task automatic test_mid_list_window();
    write_reg(CFG_WINDOW_DISTANCE, 5'd2);
    send_descending(6, 500, 1'b0);
    send_item(16'd3000, 1'b0); send_item(16'd2900, 1'b0); send_item(16'd2000, 1'b0);
    wait_idle();
    write_reg(CFG_WINDOW_DISTANCE, 5'd5);
    send_item(16'd1000, 1'b0); send_item(16'd100, 1'b0); send_item(16'd50, 1'b1);
    wait_idle();
  endtask

  task automatic test_overlong_list();
    int cur;
    write_reg(CFG_WINDOW_DISTANCE, 5'd1);
    write_reg(CFG_HALVE_GAP, 5'd0);
    cur = 60000;
    for (int p = 0; p < 4106; p++) begin
      if (p == 4095) cur = cur - 1000;
      else if (p == 4097) cur = 0;
      else if (p > 0 && cur >= 10) cur = cur - 10;
      send_item(ScoreW'(cur), p == 4105);
    end
    wait_idle();
    send_item(16'd400, 1'b0); send_item(16'd100, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_lists();
    int len;
    int kind;
    int lists;
    lists = 0;
    while (random_sent < RandomItems) begin
      if (lists % 6 == 5) begin
        wait_idle();
        if ($urandom_range(0, 7) == 0)
          write_reg(CFG_WINDOW_DISTANCE, CfgDataW'($urandom_range(0, 31)));
        else
          write_reg(CFG_WINDOW_DISTANCE, CfgDataW'($urandom_range(1, 16)));
        write_reg(CFG_HALVE_GAP, CfgDataW'($urandom_range(0, 31)));
      end else if (lists % 15 == 14) begin
        wait_idle();
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
        for (int i = 0; i < len; i++) send_item(ScoreW'($urandom_range(0, 65535)), i == len - 1);
      end else if (kind == 9) begin
        send_descending(len, 400, 1'b1);
      end else begin
        send_descending(len, 300 * (kind + 1), 1'b0);
      end
      random_sent += len;
      lists++;
    end
    wait_idle();
    write_reg(CFG_WINDOW_DISTANCE, 5'd16);
    write_reg(CFG_HALVE_GAP, 5'd1);
    send_descending(40, 2000, 1'b0);
    wait_idle();
  endtask

  initial begin
    window_reg = WINDOW_RESET;
    halve_reg = 1'b0;
    clear_list();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_lists();
    test_halving();
    test_window_limits();
    test_mid_list_window();
    test_overlong_list();
    test_random_lists();
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("window_gap_max_tracker_tb: done, clean");
    end else begin
      $display("window_gap_max_tracker_tb: done, errors");
    end
    $finish;
  end

  // receiver stall pattern, mode picked anew each time the 6-bit phase counter wraps
  logic [5:0] stall_phase = '0;
  int stall_mode = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (stall_phase[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result gap=%0d index=%0d found=%0d",
                 $time, out_best_gap, out_best_index, out_found);
      end else begin
        got_result = pending_results.pop_front();
        if (out_best_gap !== got_result.gap) begin
          errors++;
          $display("%0t: best_gap expected %0d actual %0d", $time, got_result.gap, out_best_gap);
        end
        if (out_best_index !== got_result.index) begin
          errors++;
          $display("%0t: best_index expected %0d actual %0d",
                   $time, got_result.index, out_best_index);
        end
        if (out_found !== got_result.found) begin
          errors++;
          $display("%0t: found expected %0d actual %0d", $time, got_result.found, out_found);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("window_gap_max_tracker_tb: done, errors");
      $finish;
    end
  end

endmodule
